FILE: rtl/mpgc_pkg.sv
// ----------------------------------------------------------------------------
// mpgc_pkg
// shared types, constants and velocity shaping tables for the pad gate block
// ----------------------------------------------------------------------------
package mpgc_pkg;

  localparam int unsigned PadsDef  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;
  localparam logic [7:0]  Unmapped = 8'd128;
  localparam logic [4:0]  PadNone  = 5'd16;

  typedef enum logic [2:0] {
    ACT_MIDI   = 3'd0,
    ACT_TICK   = 3'd1,
    ACT_ARM    = 3'd2,
    ACT_CANCEL = 3'd3,
    ACT_MAP    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CFG_NUM_PADS  = 3'd0,
    CFG_DEV_FILT  = 3'd1,
    CFG_CH_FILT   = 3'd2,
    CFG_TRIG_MODE = 3'd3,
    CFG_TRIG_LEN  = 3'd4,
    CFG_VEL_CURVE = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_PULSE  = 2'd0,
    MODE_GATE   = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_LATCH  = 2'd3
  } trig_mode_e;

  typedef enum logic [1:0] {
    CURVE_LIN   = 2'd0,
    CURVE_SQR   = 2'd1,
    CURVE_LOG   = 2'd2,
    CURVE_FIXED = 2'd3
  } curve_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_APPLY  = 2'd2,
    ST_OUT    = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] device_index;
    logic [4:0] channel;
    logic [1:0] msg_kind;
    logic [7:0] note;
    logic [6:0] velocity;
    logic [3:0] pad_index;
  } item_t;

  typedef struct packed {
    logic load;    // capture input item
    logic search;  // pick pad, compute level
    logic apply;   // update pad state
    logic publish; // load output register
  } cmd_t;

  // log curve: round(65536*log2((127+9v)/127)/log2(10)), 20-step fixed point
  // only used to build a constant table at elaboration
  function automatic logic [15:0] lvl_log(input logic [6:0] v);
    logic [63:0] n, d, m, acc, q;
    n = 64'd127 + 64'd9 * {57'd0, v};
    d = 64'd127;
    acc = 64'd0;
    for (int k = 0; k < 4; k++) begin
      if (n >= (d << 1)) begin
        d = d << 1;
        acc = acc + 64'd1;
      end
    end
    m = 64'd0;
    for (int k = 30; k >= 0; k--) begin
      if ((n << 30) >= (m + (64'd1 << k)) * d) m = m + (64'd1 << k);
    end
    for (int k = 0; k < 20; k++) begin
      m = (m * m) >> 30;
      acc = acc << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc = acc | 64'd1;
      end
    end
    q = 64'd0;
    for (int k = 20; k >= 0; k--) begin
      if (acc * 64'd65536 + 64'd1741647 >= (q + (64'd1 << k)) * 64'd3483294)
        q = q + (64'd1 << k);
    end
    return (q > 64'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // linear curve table, round(v*65536/127) saturated
  function automatic logic [127:0][15:0] lin_tab_init();
    logic [127:0][15:0] t;
    logic [63:0] q;
    for (int v = 0; v < 128; v++) begin
      q = (64'(v) * 64'd65536 + 64'd63) / 64'd127;
      t[v] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return t;
  endfunction

  // square curve table, round(v*v*65536/16129) saturated
  function automatic logic [127:0][15:0] sqr_tab_init();
    logic [127:0][15:0] t;
    logic [63:0] q;
    for (int v = 0; v < 128; v++) begin
      q = (64'(v) * 64'(v) * 64'd65536 + 64'd8064) / 64'd16129;
      t[v] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    end
    return t;
  endfunction

  // log curve table
  function automatic logic [127:0][15:0] log_tab_init();
    logic [127:0][15:0] t;
    for (int v = 0; v < 128; v++) begin
      t[v] = (v == 0) ? 16'd0 : lvl_log(7'(v));
    end
    return t;
  endfunction

endpackage

FILE: rtl/midi_pad_gate_controller.sv
// ----------------------------------------------------------------------------
// midi_pad_gate_controller
// each item is captured, then passes search, apply and publish in turn;
//   the next is taken only after publish, which waits for a free output
// output register lets the next item be taken while a result still waits
// reset: asynchronous active low; pads unmapped, gates low, config to defaults
// ----------------------------------------------------------------------------
module midi_pad_gate_controller import mpgc_pkg::*; #(
  parameter int unsigned Pads = PadsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action, device_index, channel, msg_kind, note, velocity, pad_index
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // gate_mask, active_count, last_pad, global_velocity, learning_pad,
  // pad_velocity
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t  cmd;
  item_t item;
  logic [62:0] res;

  // unpack tdata, first field in the lowest bits
  always_comb begin
    item.action       = s_axis_tdata[2:0];
    item.device_index = s_axis_tdata[6:3];
    item.channel      = s_axis_tdata[11:7];
    item.msg_kind     = s_axis_tdata[13:12];
    item.note         = s_axis_tdata[21:14];
    item.velocity     = s_axis_tdata[28:22];
    item.pad_index    = s_axis_tdata[32:29];
  end

  mpgc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  mpgc_datapath #(.Pads(Pads)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i (cmd),
    .item_i(item),
    .result_o(res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

FILE: rtl/mpgc_datapath.sv
// ----------------------------------------------------------------------------
// mpgc_datapath
// pad state, pad search, velocity shaping and result register
// ----------------------------------------------------------------------------
module mpgc_datapath import mpgc_pkg::*; #(
  parameter int unsigned Pads = PadsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t        cmd_i,
  input  item_t       item_i,
  output logic [62:0] result_o
);

  localparam int unsigned PW = (Pads > 1) ? $clog2(Pads) : 1;
  localparam int unsigned CW = $clog2(Pads + 1);

  localparam logic [127:0][15:0] LinTab = lin_tab_init();
  localparam logic [127:0][15:0] SqrTab = sqr_tab_init();
  localparam logic [127:0][15:0] LogTab = log_tab_init();

  logic [4:0] num_pads_q, dev_filt_q, ch_filt_q;
  logic [1:0] mode_q, curve_q;
  logic [8:0] trig_len_q;

  logic [7:0]  note_q    [Pads];
  logic [Pads-1:0] gate_q, tog_q;
  logic [15:0] level_q   [Pads];
  logic [8:0]  elapsed_q [Pads];
  logic        latched_v_q, armed_v_q, recent_v_q;
  logic [PW-1:0] latched_q, armed_q, recent_q;
  logic [15:0] recent_lvl_q;

  item_t       it_q;
  logic        hit_q;
  logic [PW-1:0] hit_pad_q;
  logic [15:0] lvl_q;
  logic [62:0] result_q;

  logic [62:0] res_d;
  logic [15:0] mask;
  logic [CW-1:0] cnt;
  logic [15:0] pv;

  logic [CW-1:0] act_n;
  always_comb begin
    act_n = ({27'd0, num_pads_q} > 32'(Pads)) ? CW'(Pads) : CW'(num_pads_q);
  end

  // event qualification
  logic pass, is_on, is_off, learn;
  logic [7:0] eff_note [Pads];
  always_comb begin
    pass = (it_q.action == ACT_MIDI) && !it_q.note[7]
        && (dev_filt_q == 5'd0 || {1'b0, it_q.device_index} == dev_filt_q - 5'd1)
        && (ch_filt_q == 5'd0 || it_q.channel == ch_filt_q);
    is_on  = pass && it_q.msg_kind == 2'd1 && it_q.velocity != 7'd0;
    is_off = pass && (it_q.msg_kind == 2'd1 || it_q.msg_kind == 2'd2) && !is_on;
    learn  = is_on && armed_v_q && (CW'(armed_q) < act_n);
    for (int i = 0; i < Pads; i++) begin
      eff_note[i] = (learn && armed_q == PW'(i)) ? it_q.note : note_q[i];
    end
  end

  // priority search across active pads
  logic found;
  logic [PW-1:0] fpad;
  always_comb begin
    found = 1'b0;
    fpad = '0;
    for (int i = Pads - 1; i >= 0; i--) begin
      if (CW'(i) < act_n && eff_note[i] == it_q.note) begin
        found = 1'b1;
        fpad = PW'(i);
      end
    end
  end

  // velocity shaping: a constant table lookup for the lin, sqr and log curves, full scale for fixed
  logic [15:0] shaped;
  always_comb begin
    case (curve_q)
      CURVE_LIN: shaped = LinTab[it_q.velocity];
      CURVE_SQR: shaped = SqrTab[it_q.velocity];
      CURVE_LOG: shaped = LogTab[it_q.velocity];
      default:   shaped = 16'hFFFF;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pads_q <= 5'd16;
      dev_filt_q <= '0;
      ch_filt_q  <= '0;
      mode_q     <= MODE_PULSE;
      trig_len_q <= 9'd10;
      curve_q    <= CURVE_LIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_PADS:  num_pads_q <= cfg_data_i[4:0];
        CFG_DEV_FILT:  dev_filt_q <= cfg_data_i[4:0];
        CFG_CH_FILT:   ch_filt_q  <= cfg_data_i[4:0];
        CFG_TRIG_MODE: mode_q     <= cfg_data_i[1:0];
        CFG_TRIG_LEN:  trig_len_q <= cfg_data_i;
        CFG_VEL_CURVE: curve_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    if (cmd_i.search) begin
      hit_q     <= is_on && found;
      hit_pad_q <= fpad;
      lvl_q     <= shaped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Pads; i++) begin
        note_q[i]    <= Unmapped;
        level_q[i]   <= '0;
        elapsed_q[i] <= '0;
      end
      gate_q <= '0;
      tog_q <= '0;
      latched_v_q <= 1'b0;
      armed_v_q <= 1'b0;
      recent_v_q <= 1'b0;
      latched_q <= '0;
      armed_q <= '0;
      recent_q <= '0;
      recent_lvl_q <= '0;
      result_q <= '0;
    end else begin
      if (cmd_i.apply) begin
        case (it_q.action)
          ACT_MIDI: begin
            if (learn) begin
              note_q[armed_q] <= it_q.note;
              armed_v_q <= 1'b0;
            end
            if (hit_q) begin
              level_q[hit_pad_q]   <= lvl_q;
              elapsed_q[hit_pad_q] <= '0;
              recent_lvl_q <= lvl_q;
              recent_q <= hit_pad_q;
              recent_v_q <= 1'b1;
              case (mode_q)
                MODE_TOGGLE: begin
                  tog_q[hit_pad_q]  <= !tog_q[hit_pad_q];
                  gate_q[hit_pad_q] <= !tog_q[hit_pad_q];
                end
                MODE_LATCH: begin
                  if (latched_v_q && latched_q != hit_pad_q) gate_q[latched_q] <= 1'b0;
                  gate_q[hit_pad_q] <= 1'b1;
                  latched_q <= hit_pad_q;
                  latched_v_q <= 1'b1;
                end
                default: gate_q[hit_pad_q] <= 1'b1;
              endcase
            end else if (is_off && found && mode_q == MODE_GATE) begin
              gate_q[fpad] <= 1'b0;
            end
          end
          ACT_TICK: begin
            for (int i = 0; i < Pads; i++) begin
              if (elapsed_q[i] != 9'd511) elapsed_q[i] <= elapsed_q[i] + 9'd1;
              if (mode_q == MODE_PULSE && gate_q[i]
                  && ((elapsed_q[i] == 9'd511 ? 9'd511 : elapsed_q[i] + 9'd1)
                      >= trig_len_q))
                gate_q[i] <= 1'b0;
            end
          end
          ACT_ARM: begin
            if ({1'b0, it_q.pad_index} < 5'(act_n)) begin
              armed_q <= PW'(it_q.pad_index);
              armed_v_q <= 1'b1;
            end
          end
          ACT_CANCEL: armed_v_q <= 1'b0;
          ACT_MAP: begin
            if (32'(it_q.pad_index) < Pads)
              note_q[PW'(it_q.pad_index)] <= it_q.note[7] ? Unmapped : it_q.note;
          end
          default: ;
        endcase
      end
      if (cmd_i.publish) result_q <= res_d;
    end
  end

  always_comb begin
    mask = '0;
    cnt = '0;
    for (int i = 0; i < Pads; i++) begin
      if (CW'(i) < act_n && gate_q[i]) begin
        if (i < 16) mask[i] = 1'b1;
        cnt = cnt + CW'(1);
      end
    end
    pv = ({1'b0, it_q.pad_index} < 5'(act_n) && 32'(it_q.pad_index) < Pads)
       ? level_q[PW'(it_q.pad_index)] : 16'd0;
    res_d = {pv,
             armed_v_q ? 5'(armed_q) : PadNone,
             recent_lvl_q,
             recent_v_q ? 5'(recent_q) : PadNone,
             (32'(cnt) > 32'd31) ? 5'd31 : 5'(cnt),
             mask};
  end

  assign result_o = result_q;

endmodule

FILE: rtl/mpgc_ctrl.sv
// ----------------------------------------------------------------------------
// mpgc_ctrl
// sequencer: capture, search, apply, publish, then output handshake
// ----------------------------------------------------------------------------
module mpgc_ctrl import mpgc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_OUT;
      ST_OUT:    if (!ov_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.search  = (state_q == ST_SEARCH);
    cmd_o.apply   = (state_q == ST_APPLY);
    cmd_o.publish = (state_q == ST_OUT) && (!ov_q || out_ready_i);
    in_ready_o    = (state_q == ST_IDLE);
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    if (cmd_o.publish) ov_d = 1'b1;
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  a_pub_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> ##3 (state_q == ST_OUT))
    else $error("sequence broken");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!ov_q || out_ready_i))
    else $error("result overwritten");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.search, cmd_o.apply, cmd_o.publish}))
    else $error("overlapping commands");

endmodule
